[sv/hcbd_pkg.sv]
package hcbd_pkg;

    typedef enum logic [3:0] {
        T_NONE    = 4'd0,
        T_BOOT    = 4'd1,
        T_CART    = 4'd2,
        T_VRAM    = 4'd3,
        T_SPRITE  = 4'd4,
        T_JOYPAD  = 4'd5,
        T_TIMER   = 4'd6,
        T_SOUND   = 4'd7,
        T_DISPLAY = 4'd8,
        T_LOCAL   = 4'd9
    } target_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_UNIMPL  = 2'd2
    } status_t;

    // where the read byte of a result comes from
    typedef enum logic [1:0] {
        RD_FIXED = 2'd0,
        RD_WRAM  = 2'd1,
        RD_HRAM  = 2'd2
    } rd_src_t;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [15:0] VRAM_BASE    = 16'h8000;
    localparam logic [15:0] XRAM_BASE    = 16'hA000;
    localparam logic [15:0] WRAM_BASE    = 16'hC000;
    localparam logic [15:0] ECHO_BASE    = 16'hE000;
    localparam logic [15:0] OAM_BASE     = 16'hFE00;
    localparam logic [15:0] OAM_LAST     = 16'hFE9F;
    localparam logic [15:0] IO_BASE      = 16'hFF00;
    localparam logic [15:0] HRAM_BASE    = 16'hFF80;
    localparam logic [15:0] BOOT_LAST    = 16'h00FF;
    localparam logic [15:0] ADDR_JOYP    = 16'hFF00;
    localparam logic [15:0] ADDR_SB      = 16'hFF01;
    localparam logic [15:0] ADDR_SC      = 16'hFF02;
    localparam logic [15:0] ADDR_DIV     = 16'hFF04;
    localparam logic [15:0] ADDR_TMA     = 16'hFF06;
    localparam logic [15:0] ADDR_TAC     = 16'hFF07;
    localparam logic [15:0] ADDR_IF      = 16'hFF0F;
    localparam logic [15:0] ADDR_NR11    = 16'hFF11;
    localparam logic [15:0] ADDR_NR21    = 16'hFF16;
    localparam logic [15:0] ADDR_NR50    = 16'hFF24;
    localparam logic [15:0] ADDR_NR52    = 16'hFF26;
    localparam logic [15:0] ADDR_SND_LO  = 16'hFF10;
    localparam logic [15:0] ADDR_WAVE_LO = 16'hFF30;
    localparam logic [15:0] ADDR_WAVE_HI = 16'hFF3F;
    localparam logic [15:0] ADDR_LCDC    = 16'hFF40;
    localparam logic [15:0] ADDR_LYC_RD  = 16'hFF45;
    localparam logic [15:0] ADDR_LY      = 16'hFF44;
    localparam logic [15:0] ADDR_DMA     = 16'hFF46;
    localparam logic [15:0] ADDR_BGP     = 16'hFF48;
    localparam logic [15:0] ADDR_WX      = 16'hFF4B;
    localparam logic [15:0] ADDR_KEY1    = 16'hFF4D;
    localparam logic [15:0] ADDR_BOOT    = 16'hFF50;
    localparam logic [15:0] ADDR_IE      = 16'hFFFF;
    localparam logic [7:0]  BOOT_UNMAP   = 8'h01;

    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_t;

    typedef struct packed {
        target_t     target;
        logic [15:0] target_offset;
        logic        target_write;
        logic [7:0]  forward_data;
        logic [7:0]  read_data;
        status_t     status;
        logic        dma_start;
        logic [7:0]  dma_page;
    } out_t;

    // decoder result: routed fields plus local state updates
    typedef struct packed {
        out_t    res;
        rd_src_t rd_src;
        logic    wram_we;
        logic    hram_we;
        logic    iflag_we;
        logic    ien_we;
        logic    boot_clear;
    } dec_t;

endpackage

[sv/hcbd_ram.sv]
module hcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/hcbd_decode.sv]
module hcbd_decode
    import hcbd_pkg::*;
(
    input  in_t        item,
    input  logic       boot_map,
    input  logic [7:0] irq_flags,
    input  logic [7:0] irq_enables,
    output dec_t       dec
);

    logic [15:0] a;
    logic [7:0]  v;
    logic        wr;

    assign a  = item.address;
    assign v  = item.write_data;
    assign wr = (item.cmd == CMD_WRITE);

    always_comb
    begin
        dec = '0;
        dec.res.target        = T_NONE;
        dec.res.target_offset = a;
        dec.res.status        = ST_UNIMPL;
        dec.rd_src            = RD_FIXED;

        if (!wr)
        begin
            if (boot_map && a <= BOOT_LAST)
            begin
                dec.res.target = T_BOOT;
                dec.res.status = ST_OK;
            end
            else if (a < VRAM_BASE || (a >= XRAM_BASE && a < WRAM_BASE))
            begin
                dec.res.target = T_CART;
                dec.res.status = ST_OK;
            end
            else if (a < XRAM_BASE)
            begin
                dec.res.target        = T_VRAM;
                dec.res.target_offset = a - VRAM_BASE;
                dec.res.status        = ST_OK;
            end
            else if (a < OAM_BASE)
            begin
                // work ram and its echo share the low address bits
                dec.res.target = T_LOCAL;
                dec.res.status = ST_OK;
                dec.rd_src     = RD_WRAM;
            end
            else if (a <= OAM_LAST)
            begin
                dec.res.target        = T_SPRITE;
                dec.res.target_offset = a - OAM_BASE;
                dec.res.status        = ST_OK;
            end
            else if (a < IO_BASE)
            begin
                // unused area, unimplemented
            end
            else if (a < HRAM_BASE || a == ADDR_IE)
            begin
                if (a == ADDR_JOYP)
                begin
                    dec.res.target = T_JOYPAD;
                    dec.res.status = ST_OK;
                end
                else if (a == ADDR_DIV || a == ADDR_TAC)
                begin
                    dec.res.target = T_TIMER;
                    dec.res.status = ST_OK;
                end
                else if (a == ADDR_IF)
                begin
                    dec.res.target    = T_LOCAL;
                    dec.res.status    = ST_OK;
                    dec.res.read_data = irq_flags;
                end
                else if (a == ADDR_NR11 || a == ADDR_NR21
                         || (a >= ADDR_NR50 && a <= ADDR_NR52))
                begin
                    dec.res.target = T_SOUND;
                    dec.res.status = ST_OK;
                end
                else if ((a >= ADDR_LCDC && a <= ADDR_LYC_RD)
                         || (a >= ADDR_BGP && a <= ADDR_WX))
                begin
                    dec.res.target = T_DISPLAY;
                    dec.res.status = ST_OK;
                end
                else if (a == ADDR_KEY1)
                begin
                    dec.res.target = T_LOCAL;
                    dec.res.status = ST_OK;
                end
                else if (a == ADDR_IE)
                begin
                    dec.res.target    = T_LOCAL;
                    dec.res.status    = ST_OK;
                    dec.res.read_data = irq_enables;
                end
            end
            else
            begin
                dec.res.target = T_LOCAL;
                dec.res.status = ST_OK;
                dec.rd_src     = RD_HRAM;
            end
        end
        else
        begin
            if (a < VRAM_BASE || (a >= XRAM_BASE && a < WRAM_BASE))
            begin
                dec.res.target = T_CART;
                dec.res.status = ST_OK;
            end
            else if (a < XRAM_BASE)
            begin
                dec.res.target        = T_VRAM;
                dec.res.target_offset = a - VRAM_BASE;
                dec.res.status        = ST_OK;
            end
            else if (a < OAM_BASE)
            begin
                dec.res.target = T_LOCAL;
                dec.res.status = ST_OK;
                dec.wram_we    = 1'b1;
            end
            else if (a <= OAM_LAST)
            begin
                dec.res.target        = T_SPRITE;
                dec.res.target_offset = a - OAM_BASE;
                dec.res.status        = ST_OK;
            end
            else if (a < IO_BASE)
            begin
                dec.res.status = ST_IGNORED;
            end
            else if (a == ADDR_DMA)
            begin
                dec.res.status    = ST_OK;
                dec.res.dma_start = 1'b1;
                dec.res.dma_page  = v;
            end
            else if (a < HRAM_BASE || a == ADDR_IE)
            begin
                if (a == ADDR_JOYP)
                begin
                    dec.res.target = T_JOYPAD;
                    dec.res.status = ST_OK;
                end
                else if (a == ADDR_SB || a == ADDR_SC || a == ADDR_KEY1)
                begin
                    dec.res.status = ST_IGNORED;
                end
                else if (a == ADDR_TMA || a == ADDR_TAC)
                begin
                    dec.res.target = T_TIMER;
                    dec.res.status = ST_OK;
                end
                else if (a == ADDR_IF)
                begin
                    dec.res.target = T_LOCAL;
                    dec.res.status = ST_OK;
                    dec.iflag_we   = 1'b1;
                end
                else if ((a >= ADDR_SND_LO && a <= ADDR_NR52)
                         || (a >= ADDR_WAVE_LO && a <= ADDR_WAVE_HI))
                begin
                    dec.res.target = T_SOUND;
                    dec.res.status = ST_OK;
                end
                else if (a >= ADDR_LCDC && a <= ADDR_WX && a != ADDR_LY)
                begin
                    dec.res.target = T_DISPLAY;
                    dec.res.status = ST_OK;
                end
                else if (a == ADDR_BOOT && v == BOOT_UNMAP)
                begin
                    dec.res.target = T_LOCAL;
                    dec.res.status = ST_OK;
                    dec.boot_clear = 1'b1;
                end
                else if (a == ADDR_IE)
                begin
                    dec.res.target = T_LOCAL;
                    dec.res.status = ST_OK;
                    dec.ien_we     = 1'b1;
                end
            end
            else
            begin
                dec.res.target = T_LOCAL;
                dec.res.status = ST_OK;
                dec.hram_we    = 1'b1;
            end

            if (dec.res.target inside {[T_BOOT:T_DISPLAY]})
            begin
                dec.res.target_write = 1'b1;
                dec.res.forward_data = v;
            end
        end
    end

endmodule

[sv/handheld_console_bus_decoder.sv]
// handheld console bus decoder
//
// in channel (in_valid/in_ready/in_data): one bus access per beat, a read or
// a write of one byte at a 16-bit address. out channel (out_valid/out_ready/
// out_data): exactly one result beat per access, in order, carrying the
// routed target, its offset, the write strobe and byte for outside targets,
// the byte of a local read, a status code and any sprite dma request.
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes the boot rom present flag;
// always ready; the user writes it only while the block is idle (not enforced).
//
// the access is decoded and the ram read issued on acceptance; the ram data
// is merged as it moves into the output register. throughput is one access
// per cycle while out_ready is high, set by the single read and write port
// of each ram; writes commit on acceptance, so a following read sees them.
// when out_ready is low the result waits in the output register and one more
// access is held in the merge stage before in_ready drops.
//
// reset clears the interrupt flag and enable registers, maps the boot rom
// overlay and sets boot rom present; work ram and high ram are not cleared.
module handheld_console_bus_decoder
    import hcbd_pkg::*;
#(
    parameter int WORK_RAM_BYTES = 8192,
    parameter int HIGH_RAM_BYTES = 127
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    localparam int WRAM_AW = (WORK_RAM_BYTES > 1) ? $clog2(WORK_RAM_BYTES) : 1;
    localparam int HRAM_AW = (HIGH_RAM_BYTES > 1) ? $clog2(HIGH_RAM_BYTES) : 1;

    // local state
    logic       boot_present_reg, boot_present_next;
    logic       boot_overlay_reg, boot_overlay_next;
    logic [7:0] irq_flags_reg,    irq_flags_next;
    logic [7:0] irq_enables_reg,  irq_enables_next;

    // merge stage and output register
    logic    s1_valid_reg, s1_valid_next;
    out_t    s1_res_reg,   s1_res_next;
    rd_src_t s1_src_reg,   s1_src_next;
    logic    out_valid_reg, out_valid_next;
    out_t    out_data_reg,  out_data_next;

    dec_t       dec;
    logic       in_fire;
    logic       s1_move;
    logic [7:0] wram_rdata;
    logic [7:0] hram_rdata;
    out_t       merged;

    assign cfg_ready = 1'b1;

    hcbd_decode u_decode (
        .item        (in_data),
        .boot_map    (boot_present_reg & boot_overlay_reg),
        .irq_flags   (irq_flags_reg),
        .irq_enables (irq_enables_reg),
        .dec         (dec)
    );

    // handshake: the merge stage moves whenever the output register is free
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    // work ram and echo use the low address bits, high ram the low seven
    hcbd_ram #(
        .WIDTH (8),
        .DEPTH (WORK_RAM_BYTES)
    ) u_wram (
        .clk   (clk),
        .we    (in_fire && dec.wram_we),
        .waddr (in_data.address[WRAM_AW-1:0]),
        .wdata (in_data.write_data),
        .re    (in_fire && dec.rd_src == RD_WRAM),
        .raddr (in_data.address[WRAM_AW-1:0]),
        .rdata (wram_rdata)
    );

    hcbd_ram #(
        .WIDTH (8),
        .DEPTH (HIGH_RAM_BYTES)
    ) u_hram (
        .clk   (clk),
        .we    (in_fire && dec.hram_we),
        .waddr (in_data.address[HRAM_AW-1:0]),
        .wdata (in_data.write_data),
        .re    (in_fire && dec.rd_src == RD_HRAM),
        .raddr (in_data.address[HRAM_AW-1:0]),
        .rdata (hram_rdata)
    );

    // ram read data is held while the merge stage stalls, since no new
    // read is issued until it moves on
    always_comb
    begin
        merged = s1_res_reg;
        case (s1_src_reg)
            RD_WRAM:  merged.read_data = wram_rdata;
            RD_HRAM:  merged.read_data = hram_rdata;
            default:  merged.read_data = s1_res_reg.read_data;
        endcase
    end

    always_comb
    begin
        boot_present_next = boot_present_reg;
        boot_overlay_next = boot_overlay_reg;
        irq_flags_next    = irq_flags_reg;
        irq_enables_next  = irq_enables_reg;
        if (cfg_valid && cfg_ready)
        begin
            boot_present_next = cfg_data;
        end
        if (in_fire)
        begin
            if (dec.boot_clear)
            begin
                boot_overlay_next = 1'b0;
            end
            if (dec.iflag_we)
            begin
                irq_flags_next = in_data.write_data;
            end
            if (dec.ien_we)
            begin
                irq_enables_next = in_data.write_data;
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_res_next    = s1_res_reg;
        s1_src_next    = s1_src_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            out_valid_next = 1'b1;
            out_data_next  = merged;
            s1_valid_next  = 1'b0;
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
            s1_res_next   = dec.res;
            s1_src_next   = dec.rd_src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_present_reg <= 1'b1;
            boot_overlay_reg <= 1'b1;
            irq_flags_reg    <= '0;
            irq_enables_reg  <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            boot_present_reg <= boot_present_next;
            boot_overlay_reg <= boot_overlay_next;
            irq_flags_reg    <= irq_flags_next;
            irq_enables_reg  <= irq_enables_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_res_reg   <= s1_res_next;
        s1_src_reg   <= s1_src_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
